>>> hdl/gclv_pkg.sv
// gclv_pkg: shared types, codes and helpers of the g-code line receiver
// no dependencies
`timescale 1ns / 1ps
package gclv_pkg;

  localparam int QueueDepthDefault = 4;
  localparam int LineLengthDefault = 128;

  // input modes
  typedef enum logic [1:0] {
    MODE_BYTE   = 2'd0,
    MODE_RETIRE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_LINE_ERR  = 3'd1,
    ST_SUM_ERR   = 3'd2,
    ST_NO_SUM    = 3'd3,
    ST_SUM_NO_N  = 3'd4,
    ST_FULL      = 3'd5,
    ST_RETIRED   = 3'd6,
    ST_EMPTY     = 3'd7
  } status_t;

  // character codes
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChN     = 8'h4E;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChM     = 8'h4D;
  localparam logic [7:0] ChOne   = 8'h31;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChTab   = 8'h09;

  localparam logic [31:0] MagCap = 32'h8000_0001;
  localparam logic [31:0] MagMin = 32'h8000_0000;
  localparam logic [31:0] PosMax = 32'h7FFF_FFFF;

  // classified input item, front to back
  typedef struct packed {
    mode_t      mode;
    logic [7:0] data;
    logic       is_eol;
    logic       is_colon;
    logic       is_semi;
    logic       is_n;
    logic       is_star;
    logic       is_nul;
    logic       is_ws;
    logic       is_sign;
    logic       is_minus;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_m;
    logic       is_one;
    logic       is_zero;
  } item_t;

  // decimal reader phases
  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  typedef struct packed {
    logic       active;
    phase_t     phase;
    logic       neg;
    logic [31:0] mag;
  } dec_t;

  localparam dec_t DecIdle = '{active: 1'b0, phase: PH_SKIP, neg: 1'b0, mag: 32'd0};

  // one character step of a decimal reader
  function automatic dec_t dec_step(dec_t d, item_t it);
    dec_t       r;
    logic [35:0] prod;
    r    = d;
    prod = ({4'd0, d.mag} << 3) + ({4'd0, d.mag} << 1) + {32'd0, it.digit};
    if (d.active) begin
      unique case (d.phase)
        PH_SKIP: begin
          if (it.is_ws) begin
            r.phase = PH_SKIP;
          end else if (it.is_sign) begin
            r.neg   = it.is_minus;
            r.phase = PH_DIGITS;
          end else if (it.is_digit) begin
            r.mag   = {28'd0, it.digit};
            r.phase = PH_DIGITS;
          end else begin
            r.phase = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (it.is_digit) begin
            r.mag = (prod > {4'd0, MagMin}) ? MagCap : prod[31:0];
          end else begin
            r.phase = PH_DONE;
          end
        end
        default: r.phase = PH_DONE;
      endcase
    end
    return r;
  endfunction

endpackage

>>> hdl/gclv_rx_if.sv
// gclv_rx_if / gclv_res_if: handshake channels of the line receiver
// no dependencies
`timescale 1ns / 1ps
interface gclv_rx_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] rx_byte;
  modport source (output valid, mode, rx_byte, input ready);
  modport sink (input valid, mode, rx_byte, output ready);
endinterface

interface gclv_res_if;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic signed [31:0] last_line;
  logic [6:0]        line_length;
  logic [1:0]        slot;
  logic [2:0]        queued;
  modport source (output valid, status, last_line, line_length, slot, queued, input ready);
  modport sink (input valid, status, last_line, line_length, slot, queued, output ready);
endinterface

>>> hdl/gclv_front.sv
// gclv_front: accepts received items and classifies the character
// depends on gclv_pkg, gclv_rx_if
`timescale 1ns / 1ps
module gclv_front import gclv_pkg::*; (
  input  logic  rst,
  gclv_rx_if.sink rx,
  output logic  push,
  output item_t push_item,
  input  logic  full
);

  logic [7:0] c;
  assign c = rx.rx_byte;

  // take an item whenever the queue has room and reset is low
  assign rx.ready = !full && !rst;
  assign push     = rx.valid && rx.ready;

  // character classification
  always_comb begin
    push_item.mode     = mode_t'(rx.mode);
    push_item.data     = c;
    push_item.is_eol   = (c == ChLf) || (c == ChCr);
    push_item.is_colon = (c == ChColon);
    push_item.is_semi  = (c == ChSemi);
    push_item.is_n     = (c == ChN);
    push_item.is_star  = (c == ChStar);
    push_item.is_nul   = (c == 8'd0);
    push_item.is_ws    = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    push_item.is_sign  = (c == ChPlus) || (c == ChMinus);
    push_item.is_minus = (c == ChMinus);
    push_item.is_digit = (c >= ChZero) && (c <= (ChZero + 8'd9));
    push_item.digit    = 4'(c - ChZero);
    push_item.is_m     = (c == ChM);
    push_item.is_one   = (c == ChOne);
    push_item.is_zero  = (c == ChZero);
  end

endmodule

>>> hdl/gclv_queue.sv
// gclv_queue: two-entry queue of classified items between front and back
// depends on gclv_pkg
`timescale 1ns / 1ps
module gclv_queue import gclv_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  head_valid,
  output item_t head_item,
  input  logic  pop
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_item;
  end

endmodule

>>> hdl/gclv_back.sv
// gclv_back: line assembly, incremental checks, slot ring and result register
// depends on gclv_pkg, gclv_res_if
`timescale 1ns / 1ps
module gclv_back import gclv_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  parameter int LINE_LENGTH = LineLengthDefault
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  item_t head_item,
  output logic  pop,
  gclv_res_if.source res
);

  localparam int SW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(LINE_LENGTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [SW-1:0]  LastSlot = SW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0]  LenLimit = CW'(LINE_LENGTH - 1);
  localparam logic [QCW-1:0] QDepth   = QCW'(QUEUE_DEPTH);

  // line store, written only
  logic [7:0] line_store [QUEUE_DEPTH][LINE_LENGTH];

  logic [SW-1:0]  read_slot, read_slot_next;
  logic [SW-1:0]  write_slot, write_slot_next;
  logic [QCW-1:0] queue_count, queue_count_next;
  logic [CW-1:0]  char_count, char_count_next;
  logic           in_comment, in_comment_next;
  logic [31:0]    last_number, last_number_next;
  logic [7:0]     running_xor, running_xor_next;
  logic           has_n, has_n_next;
  logic           has_star, has_star_next;
  logic           has_resync, has_resync_next;
  logic           nul_seen, nul_seen_next;
  logic [1:0]     resync_match, resync_match_next;
  dec_t           num_dec, num_dec_next;
  dec_t           sum_dec, sum_dec_next;

  logic           out_valid;
  status_t        out_status;
  logic [31:0]    out_last;
  logic [6:0]     out_len;
  logic [1:0]     out_slot;
  logic [2:0]     out_queued;

  logic           emit;
  status_t        emit_status;
  logic [CW-1:0]  emit_len;
  logic [SW-1:0]  emit_slot;
  logic           store_en;
  logic           line_end;
  logic [31:0]    number_value;
  logic           sum_bad;
  item_t          it;

  assign it  = head_item;
  assign pop = head_valid && (!out_valid || res.ready);

  function automatic logic [SW-1:0] next_slot(logic [SW-1:0] s);
    return (s == LastSlot) ? '0 : s + 1'b1;
  endfunction

  // line number and checksum values from the decimal readers
  always_comb begin
    if (num_dec.neg) begin
      number_value = (num_dec.mag >= MagMin) ? MagMin : (32'd0 - num_dec.mag);
    end else begin
      number_value = (num_dec.mag > PosMax) ? PosMax : num_dec.mag;
    end
    sum_bad = (sum_dec.neg && (sum_dec.mag != 32'd0)) ||
              (sum_dec.mag != {24'd0, running_xor});
  end

  assign line_end = it.is_eol || (it.is_colon && !in_comment) || (char_count >= LenLimit);

  // next state of the receiver
  always_comb begin
    read_slot_next    = read_slot;
    write_slot_next   = write_slot;
    queue_count_next  = queue_count;
    char_count_next   = char_count;
    in_comment_next   = in_comment;
    last_number_next  = last_number;
    running_xor_next  = running_xor;
    has_n_next        = has_n;
    has_star_next     = has_star;
    has_resync_next   = has_resync;
    nul_seen_next     = nul_seen;
    resync_match_next = resync_match;
    num_dec_next      = num_dec;
    sum_dec_next      = sum_dec;
    emit              = 1'b0;
    emit_status       = ST_ACCEPTED;
    emit_len          = '0;
    emit_slot         = write_slot;
    store_en          = 1'b0;

    if (pop) begin
      unique case (it.mode)
        MODE_RETIRE: begin
          emit      = 1'b1;
          emit_slot = read_slot;
          if (queue_count == '0) begin
            emit_status = ST_EMPTY;
          end else begin
            emit_status      = ST_RETIRED;
            queue_count_next = queue_count - 1'b1;
            read_slot_next   = next_slot(read_slot);
          end
        end
        MODE_CLEAR: begin
          if (queue_count != '0) begin
            write_slot_next  = next_slot(read_slot);
            queue_count_next = QCW'(1);
            char_count_next  = '0;
            in_comment_next  = 1'b0;
          end
        end
        MODE_BYTE: begin
          if (queue_count >= QDepth) begin
            emit        = 1'b1;
            emit_status = ST_FULL;
            emit_len    = char_count;
          end else if (line_end) begin
            char_count_next = '0;
            if (char_count == '0) begin
              in_comment_next = 1'b0;
            end else if (!in_comment) begin
              // line complete: run the checks
              emit     = 1'b1;
              emit_len = char_count;
              if (has_n) begin
                if ((number_value != last_number + 32'd1) && !has_resync) begin
                  emit_status = ST_LINE_ERR;
                end else if (!has_star) begin
                  emit_status = ST_NO_SUM;
                end else if (sum_bad) begin
                  emit_status = ST_SUM_ERR;
                end else begin
                  emit_status = ST_ACCEPTED;
                end
              end else if (has_star) begin
                emit_status = ST_SUM_NO_N;
              end else begin
                emit_status = ST_ACCEPTED;
              end
              if (emit_status == ST_ACCEPTED) begin
                if (has_n) last_number_next = number_value;
                write_slot_next  = next_slot(write_slot);
                queue_count_next = queue_count + 1'b1;
              end
            end
          end else begin
            in_comment_next = in_comment || it.is_semi;
            if (!(in_comment || it.is_semi)) begin
              store_en        = 1'b1;
              char_count_next = char_count + 1'b1;
              if (it.is_nul) begin
                nul_seen_next = 1'b1;
              end else if (!nul_seen) begin
                // incremental checks on a stored character
                num_dec_next = dec_step(num_dec, it);
                sum_dec_next = dec_step(sum_dec, it);
                if (it.is_n && !has_n) begin
                  has_n_next          = 1'b1;
                  num_dec_next        = DecIdle;
                  num_dec_next.active = 1'b1;
                end
                if (it.is_star && !has_star) begin
                  has_star_next       = 1'b1;
                  sum_dec_next        = DecIdle;
                  sum_dec_next.active = 1'b1;
                end
                if (!(has_star || it.is_star)) running_xor_next = running_xor ^ it.data;
                if ((resync_match == 2'd0 && it.is_m) || (resync_match == 2'd1 && it.is_one) ||
                    (resync_match == 2'd2 && it.is_one)) begin
                  resync_match_next = resync_match + 2'd1;
                end else if (resync_match == 2'd3 && it.is_zero) begin
                  has_resync_next   = 1'b1;
                  resync_match_next = 2'd0;
                end else begin
                  resync_match_next = it.is_m ? 2'd1 : 2'd0;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
      // a line that starts over drops all parse state but the comment flag
      if (char_count_next == '0) begin
        running_xor_next  = 8'd0;
        has_n_next        = 1'b0;
        has_star_next     = 1'b0;
        has_resync_next   = 1'b0;
        nul_seen_next     = 1'b0;
        resync_match_next = 2'd0;
        num_dec_next      = DecIdle;
        sum_dec_next      = DecIdle;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      read_slot    <= '0;
      write_slot   <= '0;
      queue_count  <= '0;
      char_count   <= '0;
      in_comment   <= 1'b0;
      last_number  <= 32'd0;
      running_xor  <= 8'd0;
      has_n        <= 1'b0;
      has_star     <= 1'b0;
      has_resync   <= 1'b0;
      nul_seen     <= 1'b0;
      resync_match <= 2'd0;
      num_dec      <= DecIdle;
      sum_dec      <= DecIdle;
      out_valid    <= 1'b0;
    end else begin
      read_slot    <= read_slot_next;
      write_slot   <= write_slot_next;
      queue_count  <= queue_count_next;
      char_count   <= char_count_next;
      in_comment   <= in_comment_next;
      last_number  <= last_number_next;
      running_xor  <= running_xor_next;
      has_n        <= has_n_next;
      has_star     <= has_star_next;
      has_resync   <= has_resync_next;
      nul_seen     <= nul_seen_next;
      resync_match <= resync_match_next;
      num_dec      <= num_dec_next;
      sum_dec      <= sum_dec_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_status <= emit_status;
      out_last   <= last_number_next;
      out_len    <= 7'(emit_len);
      out_slot   <= 2'(emit_slot);
      out_queued <= 3'(queue_count_next);
    end
  end

  // character store
  always_ff @(posedge clk) begin
    if (store_en) line_store[write_slot][char_count] <= it.data;
  end

  assign res.valid       = out_valid;
  assign res.status      = out_status;
  assign res.last_line   = out_last;
  assign res.line_length = out_len;
  assign res.slot        = out_slot;
  assign res.queued      = out_queued;

endmodule

>>> hdl/gcode_line_receiver_validator_top.sv
// gcode_line_receiver_validator_top: serial g-code line receiver and checker
// depends on gclv_pkg, gclv_rx_if, gclv_res_if, gclv_front, gclv_queue, gclv_back
//
// usage
//   rx channel: one item per transfer, mode 0 carries a received character,
//   mode 1 retires the oldest queued line, mode 2 clears all but the oldest.
//   res channel: at most one result per item (status, last accepted line
//   number, line length, slot, lines queued).
//   throughput: one item per cycle unless a held result stalls; the back
//   end executes one item per cycle out of a two-entry queue behind the
//   classifying front end. An item is written to the queue at its
//   transfer; the back end takes it from the queue head and loads the
//   result register, and waits while an unaccepted result is held.
//   line checks run character by character, so a line end costs no more
//   than any other character.
//   when the receiver stalls the result register holds; the back end stops,
//   the queue fills, and rx ready falls after at most two more transfers.
//   reset is synchronous and clears the ring, the counters and the parse
//   state; the line store is not cleared and needs no clearing pass.
//   rx ready is low while reset is asserted.
`timescale 1ns / 1ps
module gcode_line_receiver_validator_top import gclv_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault,
  parameter int LINE_LENGTH = LineLengthDefault
) (
  input logic clk,
  input logic rst,
  gclv_rx_if.sink    rx_ch,
  gclv_res_if.source res_ch
);

  logic  push;
  item_t push_item;
  logic  full;
  logic  head_valid;
  item_t head_item;
  logic  pop;

  // classification
  gclv_front u_front (
    .rst       (rst),
    .rx        (rx_ch),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  // decoupling queue
  gclv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  // execution
  gclv_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .LINE_LENGTH (LINE_LENGTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .res        (res_ch)
  );

endmodule

>>> dv/gclv_checker.sv
// gclv_checker: watches the rx and result channels of the line receiver,
// predicts every result and compares it; depends on gclv_pkg and the channel interfaces
`timescale 1ns / 1ps
module gclv_checker import gclv_pkg::*; (
  input  logic clk,
  input  logic rst,
  gclv_rx_if   rx_ch,
  gclv_res_if  res_ch,
  output int   fails,
  output int   pending
);

  localparam int Depth = QueueDepthDefault;
  localparam int LineLen = LineLengthDefault;

  typedef struct {
    status_t     st;
    logic [31:0] last;
    logic [6:0]  len;
    logic [1:0]  slot;
    logic [2:0]  queued;
  } line_result_t;

  line_result_t result_q[$];

  // predicted state of the receiver
  logic [7:0]  line_mem [0:Depth*LineLen-1];
  int unsigned rd_slot, wr_slot, line_cnt, chars;
  bit          comment_on;
  logic [31:0] last_num;

  assign pending = result_q.size();

  function automatic int unsigned bump(int unsigned s);
    return (s + 1 >= Depth) ? 0 : s + 1;
  endfunction

  function automatic void note(status_t st, int unsigned len, int unsigned s);
    line_result_t r;
    r.st = st;
    r.last = last_num;
    r.len = len[6:0];
    r.slot = s[1:0];
    r.queued = line_cnt[2:0];
    result_q.push_back(r);
  endfunction

  // signed decimal: skip blanks, one sign, digits with a cap just above 2^31
  function automatic void parse_dec(int unsigned s, int unsigned pos, int unsigned len,
                                    output longint unsigned mag, output bit neg);
    logic [7:0] c;
    mag = 0;
    neg = 0;
    while (pos < len) begin
      c = line_mem[s*LineLen+pos];
      if (c == ChSpace || (c >= 8'd9 && c <= 8'd13)) pos++;
      else break;
    end
    if (pos < len) begin
      c = line_mem[s*LineLen+pos];
      if (c == ChPlus || c == ChMinus) begin
        neg = (c == ChMinus);
        pos++;
      end
    end
    while (pos < len) begin
      c = line_mem[s*LineLen+pos];
      if (c < ChZero || c > 8'h39) break;
      mag = mag * 10 + (c - ChZero);
      if (mag > 64'h8000_0000) mag = 64'h8000_0001;
      pos++;
    end
  endfunction

  // checks of a finished line
  function automatic void close_line();
    int unsigned len, npos, spos, cnt, m110;
    bit has_n, has_star, resync;
    logic [7:0] c, sum;
    longint unsigned mag;
    bit neg;
    logic [31:0] num;
    len = 0; npos = 0; spos = 0; m110 = 0;
    has_n = 0; has_star = 0; resync = 0; sum = 0;
    cnt = chars;
    while (len < cnt && line_mem[wr_slot*LineLen+len] != 8'd0) len++;
    for (int unsigned i = 0; i < len; i++) begin
      c = line_mem[wr_slot*LineLen+i];
      if (c == ChN && !has_n) begin has_n = 1; npos = i; end
      if (c == ChStar && !has_star) begin has_star = 1; spos = i; end
      if (!has_star) sum ^= c;
      if ((m110 == 0 && c == ChM) || (m110 == 1 && c == ChOne) || (m110 == 2 && c == ChOne)) begin
        m110++;
      end else if (m110 == 3 && c == ChZero) begin
        resync = 1;
        m110 = 0;
      end else begin
        m110 = (c == ChM) ? 1 : 0;
      end
    end
    chars = 0;
    if (has_n) begin
      parse_dec(wr_slot, npos + 1, len, mag, neg);
      if (neg) num = (mag >= 64'h8000_0000) ? MagMin : 32'd0 - mag[31:0];
      else num = (mag > 64'h7FFF_FFFF) ? PosMax : mag[31:0];
      if (num != last_num + 32'd1 && !resync) begin
        note(ST_LINE_ERR, cnt, wr_slot);
        return;
      end
      if (!has_star) begin
        note(ST_NO_SUM, cnt, wr_slot);
        return;
      end
      parse_dec(wr_slot, spos + 1, len, mag, neg);
      if ((neg && mag != 0) || mag != {56'd0, sum}) begin
        note(ST_SUM_ERR, cnt, wr_slot);
        return;
      end
      last_num = num;
    end else if (has_star) begin
      note(ST_SUM_NO_N, cnt, wr_slot);
      return;
    end
    line_cnt++;
    note(ST_ACCEPTED, cnt, wr_slot);
    wr_slot = bump(wr_slot);
  endfunction

  // one accepted item
  function automatic void apply_item(mode_t m, logic [7:0] c);
    int unsigned s;
    case (m)
      MODE_RETIRE: begin
        if (line_cnt == 0) begin
          note(ST_EMPTY, 0, rd_slot);
        end else begin
          s = rd_slot;
          line_cnt--;
          rd_slot = bump(rd_slot);
          note(ST_RETIRED, 0, s);
        end
      end
      MODE_CLEAR: begin
        if (line_cnt > 0) begin
          wr_slot = bump(rd_slot);
          line_cnt = 1;
          chars = 0;
          comment_on = 0;
        end
      end
      MODE_BYTE: begin
        if (line_cnt >= Depth) begin
          note(ST_FULL, chars, wr_slot);
        end else if (c == ChLf || c == ChCr || (c == ChColon && !comment_on) ||
                     chars >= LineLen - 1) begin
          if (chars == 0) comment_on = 0;
          else if (comment_on) chars = 0;
          else close_line();
        end else begin
          if (c == ChSemi) comment_on = 1;
          if (!comment_on) begin
            line_mem[wr_slot*LineLen+chars] = c;
            chars++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    line_result_t e;
    if (rst) begin
      rd_slot = 0; wr_slot = 0; line_cnt = 0; chars = 0;
      comment_on = 0; last_num = 0;
      result_q.delete();
      fails <= 0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) apply_item(mode_t'(rx_ch.mode), rx_ch.rx_byte);
      if (res_ch.valid && res_ch.ready) begin
        if (result_q.size() == 0) begin
          if (fails < 10) $display("unexpected result: status %0d", res_ch.status);
          fails <= fails + 1;
        end else begin
          e = result_q.pop_front();
          if (res_ch.status != e.st || res_ch.last_line != e.last ||
              res_ch.line_length != e.len || res_ch.slot != e.slot ||
              res_ch.queued != e.queued) begin
            if (fails < 10)
              $display("mismatch: exp st %0d last %0d len %0d slot %0d q %0d, got %0d %0d %0d %0d %0d",
                       e.st, $signed(e.last), e.len, e.slot, e.queued, res_ch.status,
                       res_ch.last_line, res_ch.line_length, res_ch.slot, res_ch.queued);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

>>> dv/tb.sv
// tb: stimulus and verdict for the g-code line receiver
// depends on gclv_pkg, the channel interfaces, gclv_checker and the top level
`timescale 1ns / 1ps
module tb;
  import gclv_pkg::*;

  logic clk = 0;
  logic rst = 1;
  int   fails, pending;
  int   sent_items = 0;
  bit   calm = 0;
  int   next_n = 1;

  gclv_rx_if  rx_ch();
  gclv_res_if res_ch();

  gcode_line_receiver_validator_top dut (.clk(clk), .rst(rst), .rx_ch(rx_ch), .res_ch(res_ch));
  gclv_checker chk (.clk(clk), .rst(rst), .rx_ch(rx_ch), .res_ch(res_ch),
                    .fails(fails), .pending(pending));

  always #5 clk = ~clk;

  initial begin
    rx_ch.valid = 0;
    rx_ch.mode = MODE_BYTE;
    rx_ch.rx_byte = 0;
    res_ch.ready = 0;
  end

  // result side: random stall before each transfer
  initial begin
    int n;
    @(negedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        res_ch.ready <= 0;
        repeat (n) @(negedge clk);
      end
      res_ch.ready <= 1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      @(negedge clk);
    end
  end

  // one rx transfer after a random gap
  task automatic send(mode_t m, logic [7:0] b);
    int n;
    n = calm ? 0 : $urandom_range(0, 4);
    if (n > 0) begin
      rx_ch.valid <= 0;
      repeat (n) @(negedge clk);
    end
    rx_ch.mode <= m;
    rx_ch.rx_byte <= b;
    rx_ch.valid <= 1;
    do @(posedge clk); while (!rx_ch.ready);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(MODE_BYTE, s[i]);
  endtask

  // a command with optional checksum, right or corrupted, and a terminator
  task automatic send_cmd(string body, bit add_sum, bit good_sum, logic [7:0] term);
    logic [7:0] x;
    x = 0;
    for (int i = 0; i < body.len(); i++) x ^= body[i];
    if (!good_sum) x ^= 8'($urandom_range(1, 255));
    send_text(body);
    if (add_sum) send_text($sformatf("*%0d", x));
    send(MODE_BYTE, term);
  endtask

  task automatic resync();
    int k;
    k = $urandom_range(0, 100000);
    send_cmd($sformatf("N%0d M110", k), 1, 1, ChLf);
    next_n = k + 1;
  endtask

  task automatic good_line(logic [7:0] term);
    send_cmd($sformatf("N%0d G1 X%0d Y%0d", next_n, $urandom_range(0, 999),
                       $urandom_range(0, 999)), 1, 1, term);
    next_n++;
  endtask

  initial begin
    int r;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed cases
    send(MODE_RETIRE, 8'h00);
    send(MODE_BYTE, ChLf);
    send_cmd("N1 G28", 1, 1, ChLf);
    send_cmd("N5 G1", 1, 1, ChCr);
    send_cmd("N2 G1", 0, 1, ChLf);
    send_cmd("N2 G1", 1, 0, ChLf);
    send_cmd("G1 X1", 1, 1, ChLf);
    send_cmd("N\t+2 G0", 1, 1, ChColon);
    send_cmd("N -99999999999 M110", 1, 1, ChLf);
    send_cmd("N99999999999", 1, 1, ChLf);
    send_text("G1 ;note\nG2\n\n");
    send_text("N3 G1");
    send(MODE_BYTE, 8'h00);
    send_text("*7\n");
    send_cmd("G4", 0, 1, ChLf);
    send(MODE_BYTE, 8'hFF);
    send_text("G1*-0\n");
    for (int i = 0; i < 130; i++) send(MODE_BYTE, 8'h47);
    send(MODE_BYTE, ChLf);
    send_text("X\nY\n");
    send(MODE_BYTE, ChLf);
    send(MODE_NONE, 8'hA5);
    send(MODE_CLEAR, 8'h5A);
    send_text("G1\nG2\nG3\nG4\n");
    for (int i = 0; i < 4; i++) send(MODE_RETIRE, 8'h00);
    send(MODE_CLEAR, 8'h00);
    resync();

    // random mix: mostly well formed numbered lines with checksums
    while (sent_items < 1500) begin
      if (sent_items % 300 < 60) calm = 1;
      else calm = 0;
      r = $urandom_range(0, 99);
      if (r < 55) good_line(($urandom_range(0, 3) == 0) ? ChCr : ChLf);
      else if (r < 62) resync();
      else if (r < 67) send_cmd($sformatf("N%0d G1", next_n + $urandom_range(1, 3)), 1, 1, ChLf);
      else if (r < 72) begin
        send_cmd($sformatf("N%0d G1", next_n), 1, 0, ChLf);
      end else if (r < 76) begin
        send_cmd($sformatf("N%0d M105 ;x", next_n), 1, 1, ChLf);
        if ($urandom_range(0, 1)) send(MODE_BYTE, ChLf);
      end else if (r < 82) begin
        repeat ($urandom_range(1, 8)) send(MODE_BYTE, 8'($urandom_range(0, 255)));
      end else if (r < 86) send(MODE_CLEAR, 8'($urandom));
      else if (r < 88) send(MODE_NONE, 8'($urandom));
      else repeat ($urandom_range(1, 4)) send(MODE_RETIRE, 8'($urandom));
      if ($urandom_range(0, 9) < 6) send(MODE_RETIRE, 8'($urandom));
    end

    rx_ch.valid <= 0;
    calm = 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit
  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
hdl/gclv_pkg.sv
hdl/gclv_rx_if.sv
hdl/gclv_front.sv
hdl/gclv_queue.sv
hdl/gclv_back.sv
hdl/gcode_line_receiver_validator_top.sv
dv/gclv_checker.sv
dv/tb.sv
